FILE: rtl/core/mpssa_pkg.sv
// shared constants and codes of the multi-pool session slot allocator
package mpssa_pkg;

    localparam int CHANNELS     = 16;
    localparam int SLOTS        = 16;
    localparam int VIDEO_POOLS  = 3;
    localparam int VIDEO_DEPTH  = VIDEO_POOLS * CHANNELS;
    localparam int VADDR_W      = $clog2(VIDEO_DEPTH);
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int COUNT_W      = 10;

    // request function
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // stream types
    localparam logic [2:0] TYPE_FULL    = 3'd0;
    localparam logic [2:0] TYPE_QUARTER = 3'd1;
    localparam logic [2:0] TYPE_720P    = 3'd2;
    localparam logic [2:0] TYPE_ALARM   = 3'd3;
    localparam logic [2:0] TYPE_RECORD  = 3'd4;

    // result status
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_CHANNEL = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_BAD_SLOT    = 3'd3;
    localparam logic [2:0] ST_NO_POOL     = 3'd4;

    typedef logic [SLOTS-1:0] slot_map_t;

endpackage

FILE: rtl/core/multi_pool_session_slot_allocator.sv
// top level of the multi-pool session slot allocator
//
// Grants and frees session slots, one request per cycle unless stalled. Each
// channel owns three video pools (full, quarter and 720p resolution) kept as
// used-bitmaps in a small ram, and all channels share one record pool held in
// a register. An allocate returns the lowest free slot (video pools never give
// slot 0, which is reserved) and marks it used; a free checks the slot range
// and clears the bit, even if it was already clear. The busy count saturates
// at 0 and at 1023. Errors: bad channel is checked first for every type, then
// alarm or unknown type, then pool full or bad slot; on any error nothing
// changes and slot_out is 0. Timing: a request is taken into the input stage
// while the ram reads its bitmap; from there the priority encoder and bitmap
// update run and the result lands in the output register, and a new request
// is accepted every cycle while m_tready stays high. A result waiting in the
// output register still lets an empty input stage take one word; once both
// hold a word, s_tready stays low until the result is taken.
// The read-modify-write of the bitmap ram has a bypass register covering
// a request that reads the entry written at the same edge.
// There is no clearing pass after reset: per-entry valid bits make untouched
// bitmaps read as all free.
module multi_pool_session_slot_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // channel [7:0], slot_in [15:8]
    input  logic [3:0]  s_tuser,   // func [0], stream_type [3:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // slot_out [7:0], status [10:8], busy_count [20:11], zero
);

    // input fields
    logic       in_func;
    logic [7:0] in_channel;
    logic [2:0] in_type;
    logic [7:0] in_slot;
    logic       in_accept;
    logic       in_chan_ok;
    logic       in_video;
    logic       in_record;
    logic [mpssa_pkg::VADDR_W-1:0] in_vaddr;

    assign in_func    = s_tuser[0];
    assign in_type    = s_tuser[3:1];
    assign in_channel = s_tdata[7:0];
    assign in_slot    = s_tdata[15:8];

    // input stage
    logic       s_valid_reg;
    logic       s_func_reg;
    logic       s_chan_ok_reg;
    logic       s_video_reg;
    logic       s_record_reg;
    logic [7:0] s_slot_reg;
    logic [mpssa_pkg::VADDR_W-1:0] s_vaddr_reg;
    logic       s_entry_valid_reg;
    logic       s_hit_reg;
    mpssa_pkg::slot_map_t fwd_map_reg;

    // state
    logic [mpssa_pkg::VIDEO_DEPTH-1:0]  video_valid_reg;
    mpssa_pkg::slot_map_t               record_map_reg;
    logic [mpssa_pkg::COUNT_W-1:0]      count_reg;
    logic [mpssa_pkg::COUNT_W-1:0]      count_next;

    // output register
    logic       o_valid_reg;
    logic [7:0] o_slot_reg;
    logic [2:0] o_status_reg;
    logic [mpssa_pkg::COUNT_W-1:0] o_count_reg;

    // compute
    logic                 fire;
    mpssa_pkg::slot_map_t ram_rdata;
    mpssa_pkg::slot_map_t video_map;
    mpssa_pkg::slot_map_t pool_map;
    mpssa_pkg::slot_map_t search_map;
    mpssa_pkg::slot_map_t map_next;
    logic                 found;
    logic [mpssa_pkg::SLOT_W-1:0] free_idx;
    logic [2:0]           status_next;
    logic [7:0]           slot_out_next;
    logic                 ram_we;

    assign fire      = s_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready  = !s_valid_reg || fire;
    assign in_accept = s_tvalid && s_tready;

    assign in_chan_ok = in_channel < 8'(mpssa_pkg::CHANNELS);
    assign in_video   = in_type < mpssa_pkg::TYPE_ALARM;
    assign in_record  = in_type == mpssa_pkg::TYPE_RECORD;
    assign in_vaddr   = mpssa_pkg::VADDR_W'(in_type[1:0])
                        * mpssa_pkg::VADDR_W'(mpssa_pkg::CHANNELS)
                        + mpssa_pkg::VADDR_W'(in_channel);

    mpssa_ram #(
        .WIDTH (mpssa_pkg::SLOTS),
        .DEPTH (mpssa_pkg::VIDEO_DEPTH)
    ) u_video_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s_vaddr_reg),
        .wdata (map_next),
        .re    (in_accept && in_chan_ok && in_video),
        .raddr (in_vaddr),
        .rdata (ram_rdata)
    );

    // bitmap as seen by the request in the input stage
    always_comb
    begin
        if (s_hit_reg)
        begin
            video_map = fwd_map_reg;
        end
        else if (s_entry_valid_reg)
        begin
            video_map = ram_rdata;
        end
        else
        begin
            video_map = '0;
        end
    end

    assign pool_map   = s_video_reg ? video_map : record_map_reg;
    // reserved video slot 0 looks used to the search
    assign search_map = s_video_reg
                        ? (pool_map | mpssa_pkg::slot_map_t'(1)) : pool_map;

    // lowest clear bit
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = mpssa_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!search_map[i])
            begin
                found    = 1'b1;
                free_idx = mpssa_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        status_next   = mpssa_pkg::ST_OK;
        slot_out_next = '0;
        map_next      = pool_map;
        count_next    = count_reg;
        priority if (!s_chan_ok_reg)
        begin
            status_next = mpssa_pkg::ST_BAD_CHANNEL;
        end
        else if (!s_video_reg && !s_record_reg)
        begin
            status_next = mpssa_pkg::ST_NO_POOL;
        end
        else if (s_func_reg == mpssa_pkg::FUNC_ALLOC)
        begin
            if (!found)
            begin
                status_next = mpssa_pkg::ST_FULL;
            end
            else
            begin
                map_next      = pool_map | (mpssa_pkg::slot_map_t'(1) << free_idx);
                slot_out_next = 8'(free_idx);
                if (count_reg != {mpssa_pkg::COUNT_W{1'b1}})
                begin
                    count_next = count_reg + mpssa_pkg::COUNT_W'(1);
                end
            end
        end
        else
        begin
            if (s_slot_reg >= 8'(mpssa_pkg::SLOTS))
            begin
                status_next = mpssa_pkg::ST_BAD_SLOT;
            end
            else
            begin
                map_next = pool_map
                           & ~(mpssa_pkg::slot_map_t'(1) << s_slot_reg[mpssa_pkg::SLOT_W-1:0]);
                if (count_reg != '0)
                begin
                    count_next = count_reg - mpssa_pkg::COUNT_W'(1);
                end
            end
        end
    end

    assign ram_we = fire && s_video_reg && s_chan_ok_reg
                    && (status_next == mpssa_pkg::ST_OK);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg     <= 1'b0;
            o_valid_reg     <= 1'b0;
            video_valid_reg <= '0;
            record_map_reg  <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                o_valid_reg <= 1'b1;
                count_reg   <= count_next;
                if (s_record_reg && s_chan_ok_reg && (status_next == mpssa_pkg::ST_OK))
                begin
                    record_map_reg <= map_next;
                end
            end
            else if (m_tready)
            begin
                o_valid_reg <= 1'b0;
            end

            if (ram_we)
            begin
                video_valid_reg[s_vaddr_reg] <= 1'b1;
            end
        end
    end

    // payload of the input stage, loaded with the ram read
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s_func_reg        <= in_func;
            s_chan_ok_reg     <= in_chan_ok;
            s_video_reg       <= in_video;
            s_record_reg      <= in_record;
            s_slot_reg        <= in_slot;
            s_vaddr_reg       <= in_vaddr;
            s_entry_valid_reg <= video_valid_reg[in_vaddr];
            // ram reads the old entry when it is written at the same edge
            s_hit_reg         <= ram_we && (s_vaddr_reg == in_vaddr);
            fwd_map_reg       <= map_next;
        end
        if (fire)
        begin
            o_slot_reg   <= slot_out_next;
            o_status_reg <= status_next;
            o_count_reg  <= count_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {3'b000, o_count_reg, o_status_reg, o_slot_reg};

endmodule

FILE: rtl/core/mpssa_ram.sv
// generic single-port-write, single-port-read ram with registered read
module mpssa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: tb/multi_pool_session_slot_allocator_test.sv
// self-checking testbench of the multi-pool session slot allocator
module multi_pool_session_slot_allocator_test;

    import mpssa_pkg::*;

    // one request word as the driver sees it
    typedef struct packed {
        logic       func;
        logic [7:0] channel;
        logic [2:0] stype;
        logic [7:0] slot_in;
    } request_t;

    // one reply word as it leaves the block
    typedef struct packed {
        logic [7:0]         slot;
        logic [2:0]         status;
        logic [COUNT_W-1:0] count;
    } reply_t;

    localparam int unsigned COUNT_TOP = (1 << COUNT_W) - 1;
    localparam int          IDLE_PCT  = 22;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // channel [7:0], slot_in [15:8]
    logic [3:0]  s_tuser  = '0;    // func [0], stream_type [3:1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // slot_out [7:0], status [10:8], busy_count [20:11], zero

    // predicted pool state, mirrors the block
    slot_map_t        video_map [VIDEO_DEPTH];
    slot_map_t        record_map;
    int unsigned      busy_slots;

    request_t         pending_requests [$];
    reply_t           replies_due [$];

    bit               word_taken = 1'b0;
    bit               steady     = 1'b0;   // no idling on either side while set
    int               faults     = 0;
    int               words_queued = 0;
    int               words_in   = 0;
    int               replies_checked = 0;
    int               status_tally [8];

    multi_pool_session_slot_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // applies one request to the predicted pools and returns the reply it should give
    function automatic reply_t serve_request(request_t rq);
        reply_t    rp;
        slot_map_t map;
        bit        has_pool;
        int        first;
        int        found;
        int        idx;
        rp       = '0;
        rp.status = ST_OK;
        has_pool = 1'b0;
        first    = 0;
        idx      = 0;
        map      = '0;
        if (rq.channel >= CHANNELS)
        begin
            rp.status = ST_BAD_CHANNEL;
        end
        else if (rq.stype == TYPE_FULL || rq.stype == TYPE_QUARTER || rq.stype == TYPE_720P)
        begin
            idx      = rq.stype * CHANNELS + rq.channel;
            map      = video_map[idx];
            first    = 1;       // video slot zero is reserved
            has_pool = 1'b1;
        end
        else if (rq.stype == TYPE_RECORD)
        begin
            map      = record_map;  // shared pool, channel only range-checked
            has_pool = 1'b1;
        end
        else
        begin
            rp.status = ST_NO_POOL;
        end

        if (has_pool)
        begin
            if (rq.func == FUNC_ALLOC)
            begin
                found = -1;
                for (int s = first; s < SLOTS; s++)
                begin
                    if (found < 0 && !map[s])
                        found = s;
                end
                if (found < 0)
                    rp.status = ST_FULL;
                else
                begin
                    map[found] = 1'b1;
                    rp.slot    = found[7:0];
                    if (busy_slots < COUNT_TOP)
                        busy_slots++;
                end
            end
            else if (rq.slot_in >= SLOTS)
            begin
                rp.status = ST_BAD_SLOT;
            end
            else
            begin
                // freeing an already free slot still counts down
                map[rq.slot_in] = 1'b0;
                if (busy_slots > 0)
                    busy_slots--;
            end
            if (rq.stype == TYPE_RECORD)
                record_map = map;
            else
                video_map[idx] = map;
        end
        rp.count = busy_slots[COUNT_W-1:0];
        return rp;
    endfunction

    function automatic request_t random_request(int alloc_pct);
        request_t rq;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 8)
            rq.channel = 8'($urandom_range(255, CHANNELS));
        else if (pick < 50)
            rq.channel = 8'($urandom_range(3, 0));     // crowd a few channels so pools fill
        else
            rq.channel = 8'($urandom_range(CHANNELS - 1, 0));
        pick = $urandom_range(99);
        if (pick < 4)
            rq.stype = TYPE_ALARM;
        else if (pick < 10)
            rq.stype = 3'($urandom_range(7, 5));
        else if (pick < 35)
            rq.stype = TYPE_RECORD;
        else
            rq.stype = 3'($urandom_range(VIDEO_POOLS - 1, 0));
        rq.func = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
        if (rq.func == FUNC_FREE && $urandom_range(99) < 90)
            rq.slot_in = 8'($urandom_range(SLOTS - 1, 0));
        else
            rq.slot_in = 8'($urandom_range(255));
        return rq;
    endfunction

    task automatic queue_request(logic func, logic [7:0] channel, logic [2:0] stype,
                                 logic [7:0] slot_in);
        request_t rq;
        rq.func    = func;
        rq.channel = channel;
        rq.stype   = stype;
        rq.slot_in = slot_in;
        pending_requests.push_back(rq);
        words_queued++;
    endtask

    // hold until every queued word is in and every reply is back
    task automatic drain();
        while (words_in != words_queued || replies_due.size() != 0)
            @(posedge clk);
    endtask

    // driver: new word or idle at the falling edge
    always @(negedge clk)
    begin
        request_t rq;
        if (rst_n)
        begin
            if (!s_tvalid || word_taken)
            begin
                if (pending_requests.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    rq = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {rq.slot_in, rq.channel};
                    s_tuser  <= {rq.stype, rq.func};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: takes the handshakes at the rising edge
    always @(posedge clk)
    begin
        request_t rq;
        reply_t   got;
        reply_t   want;
        word_taken = rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.slot   = m_tdata[7:0];
            got.status = m_tdata[10:8];
            got.count  = m_tdata[20:11];
            status_tally[got.status]++;
            replies_checked++;
            if (replies_due.size() == 0)
            begin
                faults++;
                $display("%0t: reply word with none expected: slot %0d status %0d count %0d",
                         $time, got.slot, got.status, got.count);
            end
            else
            begin
                want = replies_due.pop_front();
                if (got.slot !== want.slot)
                begin
                    faults++;
                    $display("%0t: slot_out expected %0d got %0d", $time, want.slot, got.slot);
                end
                if (got.status !== want.status)
                begin
                    faults++;
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, got.status);
                end
                if (got.count !== want.count)
                begin
                    faults++;
                    $display("%0t: busy_count expected %0d got %0d",
                             $time, want.count, got.count);
                end
            end
        end
        if (word_taken)
        begin
            rq.channel = s_tdata[7:0];
            rq.slot_in = s_tdata[15:8];
            rq.func    = s_tuser[0];
            rq.stype   = s_tuser[3:1];
            replies_due.push_back(serve_request(rq));
            words_in++;
        end
    end

    // stimulus
    initial
    begin
        for (int k = 0; k < VIDEO_DEPTH; k++)
            video_map[k] = '0;
        record_map = '0;
        busy_slots = 0;
        foreach (status_tally[k])
            status_tally[k] = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        queue_request(FUNC_FREE,  8'd0,   TYPE_FULL,    8'd3);    // count already at zero
        queue_request(FUNC_ALLOC, 8'd0,   TYPE_FULL,    8'd0);
        queue_request(FUNC_ALLOC, 8'd15,  TYPE_QUARTER, 8'd255);
        queue_request(FUNC_ALLOC, 8'd7,   TYPE_720P,    8'd0);
        queue_request(FUNC_ALLOC, 8'd0,   TYPE_ALARM,   8'd0);
        queue_request(FUNC_FREE,  8'd2,   3'd7,         8'd1);    // type with no pool
        queue_request(FUNC_ALLOC, 8'd9,   TYPE_RECORD,  8'd0);    // record takes slot 0
        queue_request(FUNC_ALLOC, 8'd16,  TYPE_RECORD,  8'd0);    // bad channel on record
        queue_request(FUNC_FREE,  8'd255, TYPE_FULL,    8'd255);
        queue_request(FUNC_FREE,  8'd0,   TYPE_FULL,    8'd16);   // slot just out of range
        queue_request(FUNC_FREE,  8'd0,   TYPE_RECORD,  8'd255);
        queue_request(FUNC_FREE,  8'd0,   TYPE_FULL,    8'd0);    // reserved video slot freed
        queue_request(FUNC_FREE,  8'd15,  TYPE_QUARTER, 8'd9);    // already free
        queue_request(FUNC_FREE,  8'd4,   TYPE_RECORD,  8'd0);
        // run one video pool dry, last request finds it full
        for (int k = 0; k < SLOTS; k++)
            queue_request(FUNC_ALLOC, 8'd3, TYPE_720P, 8'($urandom_range(255)));
        drain();

        // back-to-back stretch, allocate heavy
        steady = 1'b1;
        for (int k = 0; k < 300; k++)
            pending_requests.push_back(random_request(70));
        words_queued += 300;
        drain();
        steady = 1'b0;

        // random idling, filling then emptying the pools
        for (int k = 0; k < 700; k++)
            pending_requests.push_back(random_request(65));
        words_queued += 700;
        drain();
        for (int k = 0; k < 820; k++)
            pending_requests.push_back(random_request(35));
        words_queued += 820;
        drain();

        repeat (8) @(posedge clk);
        $display("%0d request words, %0d replies checked, busy count ended at %0d",
                 words_in, replies_checked, busy_slots);
        $display("replies by status: ok %0d, bad channel %0d, full %0d, bad slot %0d, no pool %0d",
                 status_tally[ST_OK], status_tally[ST_BAD_CHANNEL], status_tally[ST_FULL],
                 status_tally[ST_BAD_SLOT], status_tally[ST_NO_POOL]);
        if (faults == 0)
            $display("multi_pool_session_slot_allocator_test: clean");
        else
            $display("multi_pool_session_slot_allocator_test: errors");
        $finish;
    end

    // hang guard
    initial
    begin
        #4000000;
        $display("multi_pool_session_slot_allocator_test: errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/mpssa_pkg.sv
rtl/core/mpssa_ram.sv
rtl/core/multi_pool_session_slot_allocator.sv
tb/multi_pool_session_slot_allocator_test.sv
